@@ rtl/oleng_pkg.sv @@
`timescale 1ns / 1ps
// Package for the ordered list engine: sizes, operation and status codes,
// payload structs and the command that the top level broadcasts to the cell row.
// Depends on nothing.
package oleng_pkg;

  localparam int unsigned DEPTH = 64;
  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = 7;
  localparam int unsigned POS_W = 8;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned OP_W  = 3;
  localparam int unsigned ST_W  = 3;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND   = 3'd0,
    OP_INSERT   = 3'd1,
    OP_DEL_VAL  = 3'd2,
    OP_DEL_POS  = 3'd3,
    OP_SEARCH   = 3'd4
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_INVALID   = 3'd2,
    ST_RANGE     = 3'd3,
    ST_FULL      = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_INS  = 2'd1,
    CELL_DEL  = 2'd2
  } cell_op_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_CMP  = 2'd1,
    S_EXEC = 2'd2
  } state_e;

  typedef struct packed {
    logic [OP_W-1:0]         operation;
    logic signed [VAL_W-1:0] value;
    logic [POS_W-1:0]        position;
  } req_t;

  typedef struct packed {
    status_e          status;
    logic [CNT_W-1:0] found_position;
    logic [CNT_W-1:0] length;
  } rsp_t;

  typedef struct packed {
    cell_op_e                op;
    logic                    cmp_en;
    logic [IDX_W-1:0]        idx;
    logic signed [VAL_W-1:0] value;
  } cell_cmd_t;

endpackage

@@ rtl/oleng_cell.sv @@
`timescale 1ns / 1ps
// One list cell: holds one entry, compares it with the broadcast value and
// takes its left or right neighbour's entry on insert or delete. Uses oleng_pkg.
module oleng_cell import oleng_pkg::*; (
  input  logic                    clk_i,
  input  logic [IDX_W-1:0]        my_idx_i,
  input  cell_cmd_t               cmd_i,
  input  logic signed [VAL_W-1:0] left_i,
  input  logic signed [VAL_W-1:0] right_i,
  output logic signed [VAL_W-1:0] entry_o,
  output logic                    match_o
);

  logic signed [VAL_W-1:0] entry_q;
  logic                    match_q;

  // Entry storage is undefined until written: no reset.
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      CELL_INS: begin
        if (my_idx_i == cmd_i.idx) begin
          entry_q <= cmd_i.value;
        end else if (my_idx_i > cmd_i.idx) begin
          entry_q <= left_i;
        end
      end
      CELL_DEL: begin
        if (my_idx_i >= cmd_i.idx) begin
          entry_q <= right_i;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cmp_en) begin
      match_q <= (entry_q == cmd_i.value);
    end
  end

  assign entry_o = entry_q;
  assign match_o = match_q;

endmodule

@@ rtl/ordered_list_engine_core.sv @@
`timescale 1ns / 1ps
// Ordered list engine top level: request/response handshakes, sequencer,
// first-match encoder and the row of oleng_cell instances. Uses oleng_pkg.
//
// Usage:
//   A request transfer on in_* carries operation, value and position; each
//   request gives exactly one response transfer on out_* with status,
//   found_position and the list length after the operation.
//   Steps: a request taken moves to the compare step, where every cell
//   registers its compare; the execute step then decides, shifts the
//   cells and loads the response register.
//   Overlap: no request is taken while the one before it is in its compare
//   step of the pass over the cell row. The next request is taken in the execute cycle
//   while the response register is free or being drained.
//   Stall: if the receiver holds out_ready_i low, the finished response is
//   held in the output register; one more request is taken and compared,
//   then the engine waits in its execute step until the response drains.
//   Reset: rst_ni clears the length to zero and empties the response
//   register; the entries themselves are not cleared and need no pass.
module ordered_list_engine_core import oleng_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  req_t in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output rsp_t out_data_o
);

  state_e state_q, state_d;
  req_t   req_q;
  logic [CNT_W-1:0] count_q, count_d;
  logic   out_valid_q, out_valid_d;
  rsp_t   out_q, rsp_d;

  cell_cmd_t cmd;
  logic signed [VAL_W-1:0] entry [DEPTH];
  logic [DEPTH-1:0] cell_match;
  logic [DEPTH-1:0] match_vec;
  logic [DEPTH-1:0] first_hot;
  logic             hit;
  logic [IDX_W-1:0] hit_idx;
  logic             can_finish;
  logic             in_xfer;
  logic             commit;

  function automatic logic [IDX_W-1:0] encode_hot(input logic [DEPTH-1:0] hot);
    logic [IDX_W-1:0] idx;
    idx = '0;
    for (int unsigned i = 0; i < DEPTH; i++) begin
      if (hot[i]) begin
        idx = idx | IDX_W'(i);
      end
    end
    return idx;
  endfunction

  // Cell row: each cell sees its neighbours' entries.
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic signed [VAL_W-1:0] left, right;
    if (k == 0) begin : g_first
      assign left = cmd.value;
    end else begin : g_mid_l
      assign left = entry[k-1];
    end
    if (k == DEPTH - 1) begin : g_last
      assign right = entry[k];
    end else begin : g_mid_r
      assign right = entry[k+1];
    end
    oleng_cell u_cell (
      .clk_i    (clk_i),
      .my_idx_i (IDX_W'(k)),
      .cmd_i    (cmd),
      .left_i   (left),
      .right_i  (right),
      .entry_o  (entry[k]),
      .match_o  (cell_match[k])
    );
    // Only occupied positions may match.
    assign match_vec[k] = cell_match[k] && (CNT_W'(k) < count_q);
  end

  // Isolate the lowest matching cell and encode its index.
  assign first_hot = match_vec & (~match_vec + {{(DEPTH-1){1'b0}}, 1'b1});
  assign hit       = |match_vec;
  assign hit_idx   = encode_hot(first_hot);

  assign can_finish = !out_valid_q || out_ready_i;
  assign commit     = (state_q == S_EXEC) && can_finish;
  assign in_ready_o = (state_q == S_IDLE) || commit;
  assign in_xfer    = in_valid_i && in_ready_o;

  // Sequencer: next state, cell command and the response.
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    out_valid_d = out_valid_q && !out_ready_i;
    rsp_d       = out_q;
    cmd.op      = CELL_HOLD;
    cmd.cmp_en  = (state_q == S_CMP);
    cmd.idx     = '0;
    cmd.value   = req_q.value;

    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        state_d = S_EXEC;
      end
      S_EXEC: begin
        if (commit) begin
          state_d              = in_xfer ? S_CMP : S_IDLE;
          out_valid_d          = 1'b1;
          rsp_d.status         = ST_OK;
          rsp_d.found_position = '0;
          unique case (op_e'(req_q.operation))
            OP_APPEND: begin
              if (count_q >= CNT_W'(DEPTH)) begin
                rsp_d.status = ST_FULL;
              end else begin
                cmd.op  = CELL_INS;
                cmd.idx = count_q[IDX_W-1:0];
                count_d = count_q + 1'b1;
              end
            end
            OP_INSERT: begin
              if (req_q.position == '0) begin
                rsp_d.status = ST_INVALID;
              end else if (count_q >= CNT_W'(DEPTH)) begin
                rsp_d.status = ST_FULL;
              end else if (req_q.position > (POS_W'(count_q) + 1'b1)) begin
                rsp_d.status = ST_RANGE;
              end else begin
                cmd.op  = CELL_INS;
                cmd.idx = IDX_W'(req_q.position - 1'b1);
                count_d = count_q + 1'b1;
              end
            end
            OP_DEL_VAL: begin
              if (!hit) begin
                rsp_d.status = ST_NOT_FOUND;
              end else begin
                cmd.op  = CELL_DEL;
                cmd.idx = hit_idx;
                count_d = count_q - 1'b1;
              end
            end
            OP_DEL_POS: begin
              if (count_q == '0 || req_q.position == '0) begin
                rsp_d.status = ST_INVALID;
              end else if (req_q.position > POS_W'(count_q)) begin
                rsp_d.status = ST_RANGE;
              end else begin
                cmd.op  = CELL_DEL;
                cmd.idx = IDX_W'(req_q.position - 1'b1);
                count_d = count_q - 1'b1;
              end
            end
            OP_SEARCH: begin
              if (!hit) begin
                rsp_d.status = ST_NOT_FOUND;
              end else begin
                rsp_d.found_position = CNT_W'(hit_idx) + 1'b1;
              end
            end
            default: begin
              // Unused codes: report ok, change nothing.
            end
          endcase
          rsp_d.length = count_d;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: hold the request and the response.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      req_q <= in_data_i;
    end
    out_q <= rsp_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // The length never exceeds the row size.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("list length beyond depth");

  // No request is taken while its predecessor is still being compared.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |-> state_q != S_CMP)
    else $error("request taken during compare");

  // A new response only appears from the execute step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_EXEC))
    else $error("response raised outside execute");

  // The length changes only on a commit, where it moves by at most one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !commit |=> $stable(count_q))
    else $error("length changed without a commit");

endmodule
